// ===== hw/rtl/lnls_pkg.sv =====
// Package for the leading number length scanner.
// Holds request types, the scan phase encoding, character codes and class helpers.
// No dependencies.
package lnls_pkg;

  // Payload of one input request: one string byte and its end mark
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_req_t;

  // Payload of one result request
  typedef struct packed {
    logic [7:0] number_length;
    logic       too_long;
  } out_req_t;

  // Scan phase, one-hot
  typedef enum logic [9:0] {
    PhLead    = 10'b00_0000_0001,
    PhSignSp  = 10'b00_0000_0010,
    PhInt     = 10'b00_0000_0100,
    PhFrac    = 10'b00_0000_1000,
    PhExp     = 10'b00_0001_0000,
    PhExpSign = 10'b00_0010_0000,
    PhExpDig  = 10'b00_0100_0000,
    PhTail    = 10'b00_1000_0000,
    PhRest    = 10'b01_0000_0000,
    PhNone    = 10'b10_0000_0000
  } phase_e;

  // ASCII codes the scanner reacts to
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChExpUp = 8'h45;
  localparam logic [7:0] ChExpLo = 8'h65;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  // Largest value the length field can carry
  localparam int unsigned LenMax = 255;

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic is_sign(input logic [7:0] c);
    is_sign = (c == ChPlus) || (c == ChMinus);
  endfunction

  function automatic logic is_exp(input logic [7:0] c);
    is_exp = (c == ChExpUp) || (c == ChExpLo);
  endfunction

endpackage

// ===== hw/rtl/lnls_core.sv =====
// Scan phase machine and position counters of the leading number length scanner.
// Advances one character per step and forms the result for the closing character.
// Depends on lnls_pkg.
module lnls_core #(
  parameter int unsigned MAX_LEN = 255
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  lnls_pkg::in_req_t  char_i,
  output lnls_pkg::out_req_t res_o
);

  localparam int unsigned PosW = $clog2(MAX_LEN + 1);
  localparam int unsigned ExtW = (PosW > 8) ? PosW : 8;

  lnls_pkg::phase_e phase_q, phase_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [PosW-1:0]  end_q, end_d;
  logic             dig_q, dig_d;
  logic             tail_q, tail_d;
  logic             ovf_q, ovf_d;
  logic [7:0]       c;
  logic [PosW-1:0]  len;
  logic [ExtW-1:0]  len_ext;

  assign c = char_i.char_code;

  // Advance the phase machine by one character
  always_comb begin
    phase_d = phase_q;
    end_d   = end_q;
    dig_d   = dig_q;
    tail_d  = tail_q;
    unique case (phase_q)
      lnls_pkg::PhLead, lnls_pkg::PhSignSp: begin
        if (c != lnls_pkg::ChSpace) begin
          if (phase_q == lnls_pkg::PhLead && lnls_pkg::is_sign(c)) begin
            phase_d = lnls_pkg::PhSignSp;
          end else if (lnls_pkg::is_digit(c)) begin
            dig_d   = 1'b1;
            phase_d = lnls_pkg::PhInt;
          end else if (c == lnls_pkg::ChDot) begin
            phase_d = lnls_pkg::PhFrac;
          end else begin
            phase_d = lnls_pkg::PhNone;
          end
        end
      end
      lnls_pkg::PhInt, lnls_pkg::PhFrac: begin
        if (lnls_pkg::is_digit(c)) begin
          dig_d = 1'b1;
        end else if (c == lnls_pkg::ChDot && phase_q == lnls_pkg::PhInt) begin
          phase_d = lnls_pkg::PhFrac;
        end else if (!dig_q) begin
          phase_d = lnls_pkg::PhNone;
        end else if (lnls_pkg::is_exp(c)) begin
          end_d   = pos_q;
          phase_d = lnls_pkg::PhExp;
        end else begin
          // close the number just before this character
          end_d = pos_q;
          if (c == lnls_pkg::ChSpace) begin
            phase_d = lnls_pkg::PhTail;
          end else begin
            phase_d = lnls_pkg::PhRest;
            tail_d  = 1'b0;
          end
        end
      end
      lnls_pkg::PhExp: begin
        if (lnls_pkg::is_sign(c)) begin
          phase_d = lnls_pkg::PhExpSign;
        end else if (lnls_pkg::is_digit(c)) begin
          phase_d = lnls_pkg::PhExpDig;
        end else begin
          phase_d = lnls_pkg::PhRest;
          tail_d  = 1'b0;
        end
      end
      lnls_pkg::PhExpSign: begin
        if (lnls_pkg::is_digit(c)) begin
          phase_d = lnls_pkg::PhExpDig;
        end else begin
          phase_d = lnls_pkg::PhRest;
          tail_d  = 1'b0;
        end
      end
      lnls_pkg::PhExpDig: begin
        if (!lnls_pkg::is_digit(c)) begin
          end_d = pos_q;
          if (c == lnls_pkg::ChSpace) begin
            phase_d = lnls_pkg::PhTail;
          end else begin
            phase_d = lnls_pkg::PhRest;
            tail_d  = 1'b0;
          end
        end
      end
      lnls_pkg::PhTail: begin
        if (c != lnls_pkg::ChSpace) begin
          phase_d = lnls_pkg::PhRest;
          tail_d  = 1'b0;
        end
      end
      default: begin
        phase_d = phase_q;
      end
    endcase
  end

  // Count characters, saturating at the maximum length
  always_comb begin
    pos_d = pos_q;
    ovf_d = ovf_q;
    if (pos_q < PosW'(MAX_LEN)) begin
      pos_d = pos_q + PosW'(1);
    end else begin
      ovf_d = 1'b1;
    end
  end

  // Pick the length from the phase reached on the closing character
  always_comb begin
    unique case (phase_d)
      lnls_pkg::PhInt, lnls_pkg::PhExpDig: len = pos_d;
      lnls_pkg::PhFrac:  len = dig_d ? pos_d : '0;
      lnls_pkg::PhExp, lnls_pkg::PhExpSign, lnls_pkg::PhRest: len = end_d;
      lnls_pkg::PhTail:  len = tail_d ? pos_d : end_d;
      default:           len = '0;
    endcase
    len_ext = ExtW'(len);
    res_o.number_length = (len_ext > ExtW'(lnls_pkg::LenMax)) ? 8'hFF : len_ext[7:0];
    res_o.too_long      = ovf_d;
  end

  // Update state; drop back to the reset values after the closing character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= lnls_pkg::PhLead;
      pos_q   <= '0;
      end_q   <= '0;
      dig_q   <= 1'b0;
      tail_q  <= 1'b1;
      ovf_q   <= 1'b0;
    end else if (step_i) begin
      if (char_i.last_char) begin
        phase_q <= lnls_pkg::PhLead;
        pos_q   <= '0;
        end_q   <= '0;
        dig_q   <= 1'b0;
        tail_q  <= 1'b1;
        ovf_q   <= 1'b0;
      end else begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        end_q   <= end_d;
        dig_q   <= dig_d;
        tail_q  <= tail_d;
        ovf_q   <= ovf_d;
      end
    end
  end

endmodule

// ===== hw/rtl/leading_number_length_scanner.sv =====
// Leading number length scanner, top level.
// Input register, scan core and result register; depends on lnls_pkg and lnls_core.
//
// Usage:
//   A string enters one byte per input request (in_req_i.char_code), the final
//   byte marked by in_req_i.last_char. Only the final byte produces a result
//   request: the length of the leading number (0 if there is none) and a flag
//   set when the string ran past MAX_LEN characters, the length then saturated.
//   Lengths above 255 read as 255.
//   The final byte is first held in the input register; the result register
//   loads when that byte steps the core.
//   Throughput: one byte per cycle unless a final byte is stalled (below);
//   each byte makes one pass through the phase machine between the input
//   register and the scan state.
//   The input register advances while the result register still holds an
//   untaken result, so non-final bytes keep flowing. A final byte waits in the
//   input register only while the result register is full and stalled.
//   Reset (rst_ni low, asynchronous) drops any pending request and starts
//   a new string in the leading spaces phase. No clearing pass is needed.
module leading_number_length_scanner #(
  parameter int unsigned MAX_LEN = 255
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  lnls_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output lnls_pkg::out_req_t out_rsp_o
);

  logic               in_vld_q;
  lnls_pkg::in_req_t  in_req_q;
  logic               out_vld_q;
  lnls_pkg::out_req_t out_rsp_q;
  logic               out_free;
  logic               step;
  lnls_pkg::out_req_t res;

  // Step the core unless a final byte finds the result register blocked
  assign out_free   = !out_vld_q || out_ready_i;
  assign step       = in_vld_q && (!in_req_q.last_char || out_free);
  assign in_ready_o = !in_vld_q || step;

  // Hold the accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_req_q <= in_req_i;
    end
  end

  lnls_core #(
    .MAX_LEN (MAX_LEN)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .char_i (in_req_q),
    .res_o  (res)
  );

  // Load the result on the final byte, clear it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step && in_req_q.last_char) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && in_req_q.last_char) begin
      out_rsp_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_rsp_q;

endmodule
